// ===== sv/npcs_pkg.sv =====
// shared types and constants for the nearest palette color search block
// depends on nothing; imported by the top, controller and datapath modules of the block
`timescale 1ns / 1ps

package npcs_pkg;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 24;
  localparam int DIST_W          = 18;
  localparam int SQ_W            = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  // item kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_take;   // write item accepted, store the entry
    logic start;     // query item accepted, latch color and clear scan
    logic step;      // issue one palette read
    logic load_out;  // move best match into the output register
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_addr; // scan address is on the final entry
    logic busy;      // distance pipeline still holds entries
    logic out_free;  // output register can take a new result
  } dp_status_t;

endpackage

// ===== sv/nearest_palette_colour_search_top.sv =====
// one query at a time: in_stall is held high from the query's acceptance until its result
//   is loaded into the output register; the scan uses the single palette ram read port,
//   reading one entry a cycle; write items are taken only while idle
// reset: rst_n synchronous active low clears control state; palette is undefined until written
// top level: joins controller and datapath; depends on npcs_pkg, npcs_ctrl, npcs_dp
`timescale 1ns / 1ps

module nearest_palette_colour_search_top
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [7:0]        in_entry_index,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_nearest_index,
  output logic [DIST_W-1:0] out_nearest_distance
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  npcs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_entry_index       (in_entry_index),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .cmd                  (cmd),
    .status               (status),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule

// ===== sv/npcs_ram.sv =====
// generic simple dual port ram with one write port and a registered read port
// depends on nothing
`timescale 1ns / 1ps

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/npcs_ctrl.sv =====
// controller state machine for the palette search: accepts items, sequences the scan
// depends on npcs_pkg
`timescale 1ns / 1ps

module npcs_ctrl
  import npcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.wr_take = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/npcs_dp.sv =====
// datapath for the palette search: palette ram, distance pipeline, best tracker, output
// depends on npcs_pkg and npcs_ram
`timescale 1ns / 1ps

module npcs_dp
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_entry_index,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_nearest_index,
  output logic [DIST_W-1:0] out_nearest_distance
);

  // query color
  logic [7:0] q_red_r, q_green_r, q_blue_r;

  // scan address and pipeline tags
  logic [IDX_W-1:0] addr_r;
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_vld_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [SQ_W-1:0]  sq_red_r, sq_green_r, sq_blue_r;

  // best match so far
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;

  // output register
  logic              out_valid_r;
  logic [7:0]        out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  // write address range check
  logic [IDX_W+7:0] wr_wide;
  logic             wr_in_range;
  logic             wr_en;
  logic [COLOR_W-1:0] rd_data;

  assign wr_wide     = {{IDX_W{1'b0}}, in_entry_index};
  assign wr_in_range = wr_wide < (IDX_W + 8)'(PALETTE_ENTRIES);
  assign wr_en       = cmd.wr_take && wr_in_range;

  npcs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_wide[IDX_W-1:0]),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (cmd.step),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // latch query color
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.start) begin
      addr_r <= '0;
    end else if (cmd.step) begin
      addr_r <= addr_r + IDX_W'(1);
    end
  end

  // absolute component differences of the entry just read
  logic [7:0] d_red, d_green, d_blue;
  assign d_red   = (q_red_r   >= rd_data[23:16]) ? q_red_r   - rd_data[23:16]
                                                 : rd_data[23:16] - q_red_r;
  assign d_green = (q_green_r >= rd_data[15:8])  ? q_green_r - rd_data[15:8]
                                                 : rd_data[15:8]  - q_green_r;
  assign d_blue  = (q_blue_r  >= rd_data[7:0])   ? q_blue_r  - rd_data[7:0]
                                                 : rd_data[7:0]   - q_blue_r;

  // pipeline valid tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.step;
      s2_vld_r <= s1_vld_r;
    end
  end

  // index tags and squares
  always_ff @(posedge clk) begin
    s1_idx_r   <= addr_r;
    s2_idx_r   <= s1_idx_r;
    sq_red_r   <= {8'b0, d_red}   * {8'b0, d_red};
    sq_green_r <= {8'b0, d_green} * {8'b0, d_green};
    sq_blue_r  <= {8'b0, d_blue}  * {8'b0, d_blue};
  end

  // sum of squares and strict compare, entry zero always taken
  logic [DIST_W-1:0] dist_sum;
  logic              take_best;
  assign dist_sum  = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
  assign take_best = s2_vld_r && ((s2_idx_r == '0) || (dist_sum < best_dist_r));

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx_r  <= s2_idx_r;
      best_dist_r <= dist_sum;
    end
  end

  // output register, index gives the low byte of the entry number
  logic [IDX_W+7:0] best_idx_wide;
  assign best_idx_wide = {8'b0, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r  <= best_idx_wide[7:0];
      out_dist_r <= best_dist_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

  // status to controller
  assign status.last_addr = addr_r == IDX_W'(PALETTE_ENTRIES - 1);
  assign status.busy      = s1_vld_r || s2_vld_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  // a result only replaces one that has been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending one");

  // no palette writes during a scan
  a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_take && (cmd.step || s1_vld_r || s2_vld_r)))
    else $error("palette write during scan");

  // result is never loaded while entries are still in flight
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(s1_vld_r || s2_vld_r || cmd.step))
    else $error("result loaded before scan drained");

  // best distance stays within the largest possible square sum
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= DIST_MAX))
    else $error("distance out of range");

endmodule
